### design/scll_pkg.sv
// Package for the spike count log-likelihood accumulator.
// Holds sizes, fixed-point constants and the input and result word types.
// Depends on nothing; the accumulator imports it.
package scll_pkg;

  localparam int MAX_POSITIONS = 64;
  localparam int MAX_CELLS     = 64;
  localparam int POS_W         = $clog2(MAX_POSITIONS);
  localparam int CELL_W        = $clog2(MAX_CELLS);
  localparam int RATE_DEPTH    = MAX_POSITIONS * MAX_CELLS;
  localparam int CFG_W         = 7;
  localparam int CNT_W         = $clog2(MAX_POSITIONS + 2);
  localparam int RATE_W        = 16;
  localparam int COUNT_W       = 8;
  localparam int ACC_W         = 32;
  localparam int PROD_W        = RATE_W + COUNT_W + 1;

  // 1.0 in Q24.8.
  localparam logic [ACC_W-1:0] ONE_Q8 = ACC_W'(256);

  // Input word operation codes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_COUNT = 1'b1;

  typedef struct packed {
    logic                     op;
    logic [5:0]               position_index;
    logic [5:0]               cell_index;
    logic signed [RATE_W-1:0] log_rate;
    logic [COUNT_W-1:0]       spike_count;
    logic                     last_cell;
  } item_t;

  typedef struct packed {
    logic [5:0]              out_position;
    logic signed [ACC_W-1:0] log_posterior;
    logic                    last_position;
  } result_t;

endpackage

### design/scll_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the rate map and the accumulators; depends on nothing.
module scll_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/spike_count_log_likelihood_accumulator.sv
// A map load word is written straight into the rate map and never raises busy. A count word
// with a nonzero count holds busy for an update pass, one accumulator update per cycle
// through the rate map and accumulator RAM ports. A last-cell word then streams n results,
// one per cycle, starting the cycle after emission begins; busy drops once they are out.
// No new count word is taken until busy has dropped.
// The receiver cannot stall.
// Reset (rst, synchronous): control idle, accumulators read as zero, positions_in_use = 64.
module spike_count_log_likelihood_accumulator
  import scll_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  item_t            item,
  output logic             result_valid,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_ACC, ST_EMIT} state_t;

  state_t                  state;
  logic [CNT_W-1:0]        cnt;
  logic [CELL_W-1:0]       cell_q;
  logic [COUNT_W-1:0]      count_q;
  logic                    last_q;
  logic [CFG_W-1:0]        positions_in_use;
  logic [MAX_POSITIONS-1:0] acc_valid;

  logic                    s1_valid;
  logic [POS_W-1:0]        s1_k;
  logic                    s2_valid;
  logic [POS_W-1:0]        s2_k;
  logic signed [PROD_W-1:0] prod;

  logic                    e1_valid;
  logic [POS_W-1:0]        e1_k;
  logic                    e1_last;

  logic                    accept;
  logic [CFG_W-1:0]        n_act;
  logic                    rate_we;
  logic [$clog2(RATE_DEPTH)-1:0] rate_waddr;
  logic [$clog2(RATE_DEPTH)-1:0] rate_raddr;
  logic [RATE_W-1:0]       rate_rdata;
  logic [POS_W-1:0]        acc_raddr;
  logic [ACC_W-1:0]        acc_rdata;
  logic [ACC_W-1:0]        acc_old;
  logic [ACC_W-1:0]        acc_sum;
  logic signed [PROD_W-1:0] prod_next;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Positions in use, saturated into 1..MAX_POSITIONS.
  always_comb begin
    if (positions_in_use == '0) begin
      n_act = CFG_W'(1);
    end else if (positions_in_use > CFG_W'(MAX_POSITIONS)) begin
      n_act = CFG_W'(MAX_POSITIONS);
    end else begin
      n_act = positions_in_use;
    end
  end

  // Map loads are written straight from the input word.
  assign rate_we    = accept && (item.op == OP_LOAD) &&
                      ({1'b0, item.position_index} < 7'(MAX_POSITIONS)) &&
                      ({1'b0, item.cell_index} < 7'(MAX_CELLS));
  assign rate_waddr = {item.cell_index[CELL_W-1:0], item.position_index[POS_W-1:0]};
  assign rate_raddr = {cell_q, cnt[POS_W-1:0]};

  scll_ram #(
    .WIDTH (RATE_W),
    .DEPTH (RATE_DEPTH)
  ) u_rate_ram (
    .clk   (clk),
    .we    (rate_we),
    .waddr (rate_waddr),
    .wdata (item.log_rate),
    .raddr (rate_raddr),
    .rdata (rate_rdata)
  );

  // Stage 1 multiplies the map entry by the count; stage 2 reads and updates the sum.
  assign prod_next = $signed({1'b0, count_q}) * $signed(rate_rdata);
  assign acc_old   = acc_valid[s2_k] ? acc_rdata : '0;
  assign acc_sum   = acc_old + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign acc_raddr = (state == ST_EMIT) ? cnt[POS_W-1:0] : s1_k;

  scll_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_POSITIONS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (s2_valid),
    .waddr (s2_k),
    .wdata (acc_sum),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  // Result word: an unwritten accumulator reads as zero.
  assign result_valid          = e1_valid;
  assign result.out_position   = 6'(e1_k);
  assign result.log_posterior  = (acc_valid[e1_k] ? acc_rdata : '0) + ONE_Q8;
  assign result.last_position  = e1_last;

  // Sequencer, pipeline registers and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      cnt              <= '0;
      positions_in_use <= CFG_W'(MAX_POSITIONS);
      acc_valid        <= '0;
      s1_valid         <= 1'b0;
      s2_valid         <= 1'b0;
      e1_valid         <= 1'b0;
      e1_last          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        positions_in_use <= cfg_data;
      end
      s2_valid <= s1_valid;
      s2_k     <= s1_k;
      prod     <= prod_next;
      s1_valid <= 1'b0;
      e1_valid <= 1'b0;
      e1_last  <= 1'b0;
      if (s2_valid) begin
        acc_valid[s2_k] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (item.op == OP_COUNT)) begin
            cell_q  <= item.cell_index[CELL_W-1:0];
            count_q <= item.spike_count;
            last_q  <= item.last_cell;
            cnt     <= '0;
            if (item.spike_count != '0) begin
              state <= ST_ACC;
            end else if (item.last_cell) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_ACC: begin
          s1_valid <= (cnt < CNT_W'(MAX_POSITIONS));
          s1_k     <= cnt[POS_W-1:0];
          cnt      <= cnt + 1'b1;
          if (cnt == CNT_W'(MAX_POSITIONS + 1)) begin
            cnt   <= '0;
            state <= last_q ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          e1_valid <= (cnt < CNT_W'(n_act));
          e1_k     <= cnt[POS_W-1:0];
          e1_last  <= (cnt == CNT_W'(n_act - 1'b1));
          cnt      <= cnt + 1'b1;
          if (cnt == CNT_W'(n_act)) begin
            state     <= ST_IDLE;
            acc_valid <= '0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Results only come out while the block is busy emitting.
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (state == ST_EMIT))
    else $error("result word outside emission");

  // Accumulator writes only happen during the update pass.
  a_acc_write: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (state == ST_ACC))
    else $error("accumulator write outside update pass");

  // The final result of a time bin is followed by a gap.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_position) |=> !result_valid)
    else $error("result word after last position");

  // Within a time bin positions come out in order with no gap.
  a_pos_order: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last_position) |=>
      (result_valid && (result.out_position == 6'($past(result.out_position) + 1'b1))))
    else $error("position sequence broken");

endmodule
